[rtl/gclp_pkg.sv]
// ----------------------------------------------------------------------------
// gclp_pkg
// Shared types and constants for the G-code line word parser.
// ----------------------------------------------------------------------------
package gclp_pkg;

  // Fixed width of the value fields on the result channel
  localparam int OUT_W = 32;

  // Letter codes of a pending word
  localparam logic [2:0] LTR_G = 3'd0;
  localparam logic [2:0] LTR_M = 3'd1;
  localparam logic [2:0] LTR_X = 3'd2;
  localparam logic [2:0] LTR_Y = 3'd3;
  localparam logic [2:0] LTR_Z = 3'd4;
  localparam logic [2:0] LTR_W = 3'd5;
  localparam logic [2:0] LTR_F = 3'd6;

  // Characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_G  = 8'h47;
  localparam logic [7:0] CH_UP_M  = 8'h4D;
  localparam logic [7:0] CH_UP_W  = 8'h57;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_UP_Y  = 8'h59;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Command flag bits
  localparam int FLG_HOME  = 0;
  localparam int FLG_QUERY = 1;
  localparam int FLG_PROBE = 2;
  localparam int FLG_PZERO = 3;

  // Control from the parser sequencer to the number accumulator
  typedef struct packed {
    logic       en;        // state advances this cycle
    logic       clr;       // start of a new number
    logic       dig_int;   // integer digit
    logic       dig_frac;  // fraction digit
    logic [3:0] digit;
  } num_ctl_t;

  // Decoded view of the number held, for committing a G or M word
  typedef struct packed {
    logic [7:0] low8;      // integer part, low byte (magnitude)
    logic       is_28;
    logic       near_382;
    logic       near_383;
  } num_stat_t;

  // Powers of ten, for elaboration-time constants only
  function automatic longint unsigned pow10(input int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

endpackage

[rtl/gclp_num_acc.sv]
// ----------------------------------------------------------------------------
// gclp_num_acc
// Fixed-point decimal accumulator: keeps the magnitude already scaled to
// FRAC_DIGITS fraction digits and saturated, plus the integer part's low
// byte and a capped copy for the G code checks.
// ----------------------------------------------------------------------------
module gclp_num_acc import gclp_pkg::*; #(
  parameter int FRAC_DIGITS = 3,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  num_ctl_t               ctl,
  output logic [VALUE_WIDTH-1:0] mag,
  output num_stat_t              stat
);

  localparam int AW = VALUE_WIDTH + 5;
  localparam int SW = $clog2(FRAC_DIGITS + 1);
  localparam logic [AW-1:0] MAX_MAG  = (AW'(1) << (VALUE_WIDTH - 1)) - AW'(1);
  localparam logic [AW-1:0] SCALE    = AW'(pow10(FRAC_DIGITS));
  localparam logic [AW-1:0] TOL      = (SCALE - AW'(1)) / AW'(20);
  localparam logic [AW-1:0] C382     = AW'(382) * SCALE / AW'(10);
  localparam logic [AW-1:0] C383     = AW'(383) * SCALE / AW'(10);
  localparam logic [AW-1:0] SAT_IP   = MAX_MAG / SCALE;
  localparam logic [7:0]    SAT_LOW  = SAT_IP[7:0];
  localparam logic          SAT_28   = (SAT_IP == AW'(28));
  localparam logic [5:0]    IC_CAP   = 6'd63;

  logic [VALUE_WIDTH-1:0] s_r, s_nxt, base_s;
  logic [SW-1:0]          seen_r, seen_nxt, base_seen;
  logic [7:0]             i8_r, i8_nxt, base_i8;
  logic [5:0]             ic_r, ic_nxt, base_ic;
  logic [AW-1:0]          frac_w [FRAC_DIGITS+1];
  logic [AW-1:0]          cand, s_ext;
  logic [9:0]             ic_sum;
  logic                   sat;

  // weight of the next fraction digit, by digits already seen
  for (genvar k = 0; k <= FRAC_DIGITS; k++) begin : g_fw
    if (k < FRAC_DIGITS) begin : g_live
      assign frac_w[k] = AW'(pow10(FRAC_DIGITS - 1 - k));
    end else begin : g_end
      assign frac_w[k] = '0;
    end
  end

  always_comb begin
    base_s    = ctl.clr ? '0 : s_r;
    base_seen = ctl.clr ? '0 : seen_r;
    base_i8   = ctl.clr ? '0 : i8_r;
    base_ic   = ctl.clr ? '0 : ic_r;
    s_nxt     = base_s;
    seen_nxt  = base_seen;
    i8_nxt    = base_i8;
    ic_nxt    = base_ic;
    cand      = AW'(base_s);
    ic_sum    = 10'(base_ic) * 10'd10 + 10'(ctl.digit);
    if (ctl.dig_int) begin
      cand   = (AW'(base_s) << 3) + (AW'(base_s) << 1) + AW'(ctl.digit) * SCALE;
      i8_nxt = 8'(base_i8 * 8'd10 + 8'(ctl.digit));
      ic_nxt = (ic_sum > 10'(IC_CAP)) ? IC_CAP : ic_sum[5:0];
    end else if (ctl.dig_frac && (base_seen < SW'(FRAC_DIGITS))) begin
      cand     = AW'(base_s) + AW'(ctl.digit) * frac_w[base_seen];
      seen_nxt = base_seen + SW'(1);
    end
    s_nxt = (cand > MAX_MAG) ? MAX_MAG[VALUE_WIDTH-1:0] : cand[VALUE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r    <= '0;
      seen_r <= '0;
      i8_r   <= '0;
      ic_r   <= '0;
    end else if (ctl.en) begin
      s_r    <= s_nxt;
      seen_r <= seen_nxt;
      i8_r   <= i8_nxt;
      ic_r   <= ic_nxt;
    end
  end

  // a saturated magnitude has a fixed integer part
  assign sat   = (s_r == MAX_MAG[VALUE_WIDTH-1:0]);
  assign s_ext = AW'(s_r);
  assign mag   = s_r;

  always_comb begin
    stat.low8     = sat ? SAT_LOW : i8_r;
    stat.is_28    = sat ? SAT_28 : (ic_r == 6'd28);
    stat.near_382 = (s_ext >= C382 - TOL) && (s_ext <= C382 + TOL);
    stat.near_383 = (s_ext >= C383 - TOL) && (s_ext <= C383 + TOL);
  end

endmodule

[rtl/gcode_line_word_parser_top.sv]
// ----------------------------------------------------------------------------
// gcode_line_word_parser_top
// Streaming G-code line parser: one character per item in, one item out per
// line end carrying the line's last G/M codes, axis and feed values (in
// 10^-FRAC_DIGITS units), presence bits and command flags.
//
//   channel | ports                            | item
//   --------+----------------------------------+-------------------------------
//   in      | in_valid, in_stall, in_char_in   | one received character
//   out     | out_valid, out_stall, out_*      | fields of one finished line
//
// Flow: one character per clock while in_stall is low. A character is held in
// the input register, is parsed in a single pass against the line state and
// the number accumulator, and a line result lands in the output register on
// the same edge as the line state takes the line end.
// Reset: synchronous, active low; clears parse phase and line state at once.
// Stalls: a result waits in the output register under out_stall while later
// characters keep flowing; in_stall rises only when another line end meets
// that still-held result.
// ----------------------------------------------------------------------------
module gcode_line_word_parser_top import gclp_pkg::*; #(
  parameter int FRAC_DIGITS = 3,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // character channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_char_in,
  // line result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_line_valid,
  output logic [7:0]              out_g_code,
  output logic [7:0]              out_m_code,
  output logic signed [OUT_W-1:0] out_x_pos,
  output logic signed [OUT_W-1:0] out_y_pos,
  output logic signed [OUT_W-1:0] out_z_pos,
  output logic signed [OUT_W-1:0] out_w_pos,
  output logic signed [OUT_W-1:0] out_feed_rate,
  output logic [3:0]              out_axis_present,
  output logic [3:0]              out_command_flags
);

  typedef enum logic [2:0] {
    PH_SCAN, PH_LETTER, PH_BLANK, PH_SIGN, PH_DOT, PH_INT, PH_FRAC, PH_COMMENT
  } phase_t;

  // input register
  logic [7:0] char_r;
  logic       char_v_r;

  // line state
  phase_t     phase_r, phase_nxt;
  logic       neg_r, neg_nxt;
  logic [2:0] letter_r, letter_nxt;
  logic       seen_r, seen_nxt;
  logic [7:0] g_r, g_nxt, m_r, m_nxt;
  logic [OUT_W-1:0] axis_r [4];
  logic [OUT_W-1:0] axis_nxt [4];
  logic [OUT_W-1:0] feed_r, feed_nxt;
  logic [3:0] aseen_r, aseen_nxt;
  logic [3:0] cmd_r, cmd_nxt;

  // output register
  logic             out_v_r;
  logic             o_lv_r;
  logic [7:0]       o_g_r, o_m_r;
  logic [OUT_W-1:0] o_axis_r [4];
  logic [OUT_W-1:0] o_feed_r;
  logic [3:0]       o_aseen_r, o_cmd_r;

  // snapshot taken at a line end, before the line is cleared
  logic             s_lv;
  logic [7:0]       s_g, s_m;
  logic [OUT_W-1:0] s_axis [4];
  logic [OUT_W-1:0] s_feed;
  logic [3:0]       s_aseen, s_cmd;

  num_ctl_t               ctl;
  num_stat_t              stat;
  logic [VALUE_WIDTH-1:0] mag, mag_sgn;
  logic [63:0]            val64;
  logic [OUT_W-1:0]       val32;
  logic [7:0]             low8;

  logic [7:0] c, u;
  logic       is_digit, is_term, is_blank, is_crlf, starts_num;
  logic       emit, do_scan, do_commit, advance, accept;

  gclp_num_acc #(
    .FRAC_DIGITS(FRAC_DIGITS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_num (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl),
    .mag  (mag),
    .stat (stat)
  );

  // character classes
  assign c          = char_r;
  assign u          = ((c >= CH_LO_A) && (c <= CH_LO_Z)) ? c - CASE_OFS : c;
  assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_term    = (c == CH_NUL) || (c == CH_CR) || (c == CH_LF);
  assign is_crlf    = (c == CH_CR) || (c == CH_LF);
  assign is_blank   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  assign starts_num = is_digit || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_POINT);

  // signed value of the number being committed, as seen on a 32-bit field
  assign mag_sgn = neg_r ? VALUE_WIDTH'(0) - mag : mag;
  assign val64   = 64'(signed'(mag_sgn));
  assign val32   = val64[OUT_W-1:0];
  assign low8    = neg_r ? 8'(8'd0 - stat.low8) : stat.low8;

  always_comb begin
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    letter_nxt = letter_r;
    seen_nxt   = seen_r;
    g_nxt      = g_r;
    m_nxt      = m_r;
    axis_nxt   = axis_r;
    feed_nxt   = feed_r;
    aseen_nxt  = aseen_r;
    cmd_nxt    = cmd_r;
    ctl        = '0;
    ctl.digit  = c[3:0];
    emit       = 1'b0;
    do_scan    = 1'b0;
    do_commit  = 1'b0;

    case (phase_r)
      PH_COMMENT: begin
        emit = is_term;
      end
      PH_LETTER: begin
        if (c == CH_NUL) begin
          emit = 1'b1;
        end else begin
          // a number start attempt always clears the accumulator and sign
          ctl.clr = 1'b1;
          neg_nxt = (c == CH_MINUS);
          if (is_digit) begin
            ctl.dig_int = 1'b1;
            phase_nxt   = PH_INT;
          end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            phase_nxt = PH_SIGN;
          end else if (c == CH_POINT) begin
            phase_nxt = PH_DOT;
          end else begin
            // character after a bare letter is dropped
            phase_nxt = (is_blank || is_crlf) ? PH_BLANK : PH_SCAN;
          end
        end
      end
      PH_BLANK: begin
        if (is_blank) begin
          phase_nxt = PH_BLANK;
        end else if (starts_num) begin
          ctl.clr = 1'b1;
          neg_nxt = (c == CH_MINUS);
          if (is_digit) begin
            ctl.dig_int = 1'b1;
            phase_nxt   = PH_INT;
          end else if (c == CH_POINT) begin
            phase_nxt = PH_DOT;
          end else begin
            phase_nxt = PH_SIGN;
          end
        end else begin
          do_scan = 1'b1;
        end
      end
      PH_SIGN: begin
        if (is_digit) begin
          ctl.dig_int = 1'b1;
          phase_nxt   = PH_INT;
        end else if (c == CH_POINT) begin
          phase_nxt = PH_DOT;
        end else begin
          do_scan = 1'b1;
        end
      end
      PH_DOT: begin
        if (is_digit) begin
          ctl.dig_frac = 1'b1;
          phase_nxt    = PH_FRAC;
        end else begin
          do_scan = 1'b1;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          ctl.dig_int = 1'b1;
        end else if (c == CH_POINT) begin
          phase_nxt = PH_FRAC;
        end else begin
          do_commit = 1'b1;
          do_scan   = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          ctl.dig_frac = 1'b1;
        end else begin
          do_commit = 1'b1;
          do_scan   = 1'b1;
        end
      end
      default: begin
        do_scan = 1'b1;
      end
    endcase

    // word finished: store it under its letter
    if (do_commit) begin
      case (letter_r)
        LTR_G: begin
          g_nxt = low8;
          if (!neg_r && stat.is_28)    cmd_nxt[FLG_HOME]  = 1'b1;
          if (!neg_r && stat.near_382) cmd_nxt[FLG_PROBE] = 1'b1;
          if (!neg_r && stat.near_383) begin
            cmd_nxt[FLG_PROBE] = 1'b1;
            cmd_nxt[FLG_PZERO] = 1'b1;
          end
        end
        LTR_M: m_nxt = low8;
        LTR_X, LTR_Y, LTR_Z, LTR_W: begin
          axis_nxt[letter_r[1:0] - 2'd2]  = val32;
          aseen_nxt[letter_r[1:0] - 2'd2] = 1'b1;
        end
        default: feed_nxt = val32;
      endcase
      seen_nxt = 1'b1;
    end

    // fresh character (also a reprocessed one)
    if (do_scan) begin
      phase_nxt = PH_SCAN;
      if (is_term) begin
        emit = 1'b1;
      end else if ((c == CH_SEMI) || (c == CH_LPAR)) begin
        phase_nxt = PH_COMMENT;
      end else if (c == CH_QUERY) begin
        cmd_nxt[FLG_QUERY] = 1'b1;
        seen_nxt           = 1'b1;
      end else begin
        case (u)
          CH_UP_G: begin letter_nxt = LTR_G; phase_nxt = PH_LETTER; end
          CH_UP_M: begin letter_nxt = LTR_M; phase_nxt = PH_LETTER; end
          CH_UP_X: begin letter_nxt = LTR_X; phase_nxt = PH_LETTER; end
          CH_UP_Y: begin letter_nxt = LTR_Y; phase_nxt = PH_LETTER; end
          CH_UP_Z: begin letter_nxt = LTR_Z; phase_nxt = PH_LETTER; end
          CH_UP_W: begin letter_nxt = LTR_W; phase_nxt = PH_LETTER; end
          CH_UP_F: begin letter_nxt = LTR_F; phase_nxt = PH_LETTER; end
          default: ;
        endcase
      end
    end

    s_lv    = seen_nxt;
    s_g     = g_nxt;
    s_m     = m_nxt;
    s_axis  = axis_nxt;
    s_feed  = feed_nxt;
    s_aseen = aseen_nxt;
    s_cmd   = cmd_nxt;

    // line end: clear everything for the next line
    if (emit) begin
      phase_nxt  = PH_SCAN;
      neg_nxt    = 1'b0;
      letter_nxt = LTR_G;
      seen_nxt   = 1'b0;
      g_nxt      = '0;
      m_nxt      = '0;
      axis_nxt   = '{default: '0};
      feed_nxt   = '0;
      aseen_nxt  = '0;
      cmd_nxt    = '0;
      ctl.clr    = 1'b1;
    end

    // same condition as advance, formed here from emit
    ctl.en = char_v_r && !(emit && out_v_r && out_stall);
  end

  // held character moves on unless its result has nowhere to go
  assign advance   = char_v_r && !(emit && out_v_r && out_stall);
  assign in_stall  = char_v_r && emit && out_v_r && out_stall;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      phase_r  <= PH_SCAN;
      neg_r    <= 1'b0;
      letter_r <= LTR_G;
      seen_r   <= 1'b0;
      g_r      <= '0;
      m_r      <= '0;
      axis_r   <= '{default: '0};
      feed_r   <= '0;
      aseen_r  <= '0;
      cmd_r    <= '0;
    end else begin
      if (accept) begin
        char_r   <= in_char_in;
        char_v_r <= 1'b1;
      end else if (advance) begin
        char_v_r <= 1'b0;
      end

      if (advance) begin
        phase_r  <= phase_nxt;
        neg_r    <= neg_nxt;
        letter_r <= letter_nxt;
        seen_r   <= seen_nxt;
        g_r      <= g_nxt;
        m_r      <= m_nxt;
        axis_r   <= axis_nxt;
        feed_r   <= feed_nxt;
        aseen_r  <= aseen_nxt;
        cmd_r    <= cmd_nxt;
      end

      if (advance && emit) begin
        out_v_r   <= 1'b1;
        o_lv_r    <= s_lv;
        o_g_r     <= s_g;
        o_m_r     <= s_m;
        o_axis_r  <= s_axis;
        o_feed_r  <= s_feed;
        o_aseen_r <= s_aseen;
        o_cmd_r   <= s_cmd;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_v_r;
  assign out_line_valid    = o_lv_r;
  assign out_g_code        = o_g_r;
  assign out_m_code        = o_m_r;
  assign out_x_pos         = o_axis_r[0];
  assign out_y_pos         = o_axis_r[1];
  assign out_z_pos         = o_axis_r[2];
  assign out_w_pos         = o_axis_r[3];
  assign out_feed_rate     = o_feed_r;
  assign out_axis_present  = o_aseen_r;
  assign out_command_flags = o_cmd_r;

endmodule

[rtl/gclp_checker.sv]
// ----------------------------------------------------------------------------
// gclp_checker
// Port-level checks on the G-code line parser, bound to the top level.
// ----------------------------------------------------------------------------
module gclp_checker import gclp_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    out_line_valid,
  input logic [7:0]              out_g_code,
  input logic [7:0]              out_m_code,
  input logic signed [OUT_W-1:0] out_x_pos,
  input logic signed [OUT_W-1:0] out_y_pos,
  input logic signed [OUT_W-1:0] out_z_pos,
  input logic signed [OUT_W-1:0] out_w_pos,
  input logic signed [OUT_W-1:0] out_feed_rate,
  input logic [3:0]              out_axis_present,
  input logic [3:0]              out_command_flags
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x_pos) && $stable(out_feed_rate)
      && $stable(out_command_flags) && $stable(out_g_code))
    else $error("result changed while stalled");

  // input back-pressure only comes from a stalled, full output
  a_in_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // an empty line carries nothing
  a_empty_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_valid |-> out_g_code == 8'd0 && out_m_code == 8'd0
      && out_axis_present == 4'd0 && out_command_flags == 4'd0 && out_feed_rate == '0)
    else $error("empty line with non-zero fields");

  // probe-zero is a kind of probe
  a_pzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_flags[FLG_PZERO] |-> out_command_flags[FLG_PROBE])
    else $error("probe zero without probe");

  // absent axes read as zero
  a_axis_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_axis_present[0] || out_x_pos == '0)
      && (out_axis_present[1] || out_y_pos == '0)
      && (out_axis_present[2] || out_z_pos == '0)
      && (out_axis_present[3] || out_w_pos == '0))
    else $error("absent axis with non-zero value");

endmodule

bind gcode_line_word_parser_top gclp_checker u_gclp_checker (.*);
